// ----- src/ipsl_pkg.sv -----
package ipsl_pkg;

  localparam int IDLE_BITS  = 32;
  localparam int LEVEL_BITS = 8;
  // compare width covers both the idle counter and the 32-bit timeouts
  localparam int CMP_BITS   = (IDLE_BITS > 32) ? IDLE_BITS : 32;

  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_BITS     = 32;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DIM_TIMEOUT   = 3'd0,
    CFG_LIGHT_TIMEOUT = 3'd1,
    CFG_DEEP_TIMEOUT  = 3'd2,
    CFG_DIM_LEVEL     = 3'd3,
    CFG_ACTIVE_LEVEL  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_ACTIVITY = 2'd1,
    REQ_CRITICAL = 2'd2,
    REQ_FORCE    = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_ACTIVE = 4'b0001,
    ST_DIM    = 4'b0010,
    ST_LIGHT  = 4'b0100,
    ST_DEEP   = 4'b1000
  } state_e;

  localparam logic [1:0] CODE_ACTIVE = 2'd0;
  localparam logic [1:0] CODE_DIM    = 2'd1;
  localparam logic [1:0] CODE_LIGHT  = 2'd2;
  localparam logic [1:0] CODE_DEEP   = 2'd3;

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_CHANGE = 2'd1;
  localparam logic [1:0] EV_DEEP   = 2'd2;

  localparam logic [31:0] RST_DIM_TIMEOUT   = 32'd30000;
  localparam logic [31:0] RST_LIGHT_TIMEOUT = 32'd120000;
  localparam logic [31:0] RST_DEEP_TIMEOUT  = 32'd600000;
  localparam logic [7:0]  RST_DIM_LEVEL     = 8'd20;
  localparam logic [7:0]  RST_ACTIVE_LEVEL  = 8'd200;

  typedef struct packed {
    logic [31:0] dim_timeout;
    logic [31:0] light_timeout;
    logic [31:0] deep_timeout;
    logic [7:0]  dim_level;
    logic [7:0]  active_level;
  } cfg_t;

  typedef struct packed {
    state_e               st;
    logic [IDLE_BITS-1:0] idle;
    logic                 radio_save;
    logic                 service_on;
  } ctx_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] elapsed_ms;
    logic [2:0]  target_state;
  } item_t;

  typedef struct packed {
    logic [1:0]  power_state;
    logic        state_changed;
    logic        backlight_write;
    logic [7:0]  backlight_level;
    logic        radio_power_save;
    logic        network_service_on;
    logic [1:0]  event_code;
    logic [31:0] idle_ms_out;
    logic        status;
    logic        sleep_request;
  } result_t;

  function automatic logic [1:0] state_code(state_e st);
    logic [1:0] code;
    case (st)
      ST_ACTIVE: code = CODE_ACTIVE;
      ST_DIM:    code = CODE_DIM;
      ST_LIGHT:  code = CODE_LIGHT;
      ST_DEEP:   code = CODE_DEEP;
      default:   code = CODE_ACTIVE;
    endcase
    return code;
  endfunction

  function automatic state_e code_state(logic [1:0] code);
    state_e st;
    case (code)
      CODE_ACTIVE: st = ST_ACTIVE;
      CODE_DIM:    st = ST_DIM;
      CODE_LIGHT:  st = ST_LIGHT;
      CODE_DEEP:   st = ST_DEEP;
      default:     st = ST_ACTIVE;
    endcase
    return st;
  endfunction

  // mask to LEVEL_BITS, then fit the 8-bit field
  function automatic logic [7:0] fit_level(logic [7:0] lvl);
    return 8'(LEVEL_BITS'(lvl));
  endfunction

endpackage

// ----- src/ipsl_if.sv -----
interface ipsl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] elapsed_ms;
  logic [2:0]  target_state;

  modport source (output valid, req_type, elapsed_ms, target_state, input ready);
  modport sink   (input valid, req_type, elapsed_ms, target_state, output ready);
endinterface

interface ipsl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  power_state;
  logic        state_changed;
  logic        backlight_write;
  logic [7:0]  backlight_level;
  logic        radio_power_save;
  logic        network_service_on;
  logic [1:0]  event_code;
  logic [31:0] idle_ms_out;
  logic        status;
  logic        sleep_request;

  modport source (
    output valid, power_state, state_changed, backlight_write, backlight_level,
           radio_power_save, network_service_on, event_code, idle_ms_out,
           status, sleep_request,
    input  ready
  );
  modport sink (
    input  valid, power_state, state_changed, backlight_write, backlight_level,
           radio_power_save, network_service_on, event_code, idle_ms_out,
           status, sleep_request,
    output ready
  );
endinterface

// ----- src/ipsl_step.sv -----
module ipsl_step import ipsl_pkg::*; (
  input  cfg_t    cfg_i,
  input  ctx_t    ctx_i,
  input  item_t   item_i,
  output ctx_t    ctx_o,
  output result_t res_o
);

  logic [IDLE_BITS:0]   sum;
  logic [IDLE_BITS-1:0] idle_new;
  logic [CMP_BITS-1:0]  idle_cmp;
  logic                 go;
  state_e               tgt;
  logic                 status;
  logic                 move;

  always_comb begin
    sum      = {1'b0, ctx_i.idle} + (IDLE_BITS + 1)'(item_i.elapsed_ms);
    idle_new = sum[IDLE_BITS] ? '1 : sum[IDLE_BITS-1:0];
    idle_cmp = CMP_BITS'(idle_new);
  end

  always_comb begin
    ctx_o  = ctx_i;
    go     = 1'b0;
    tgt    = ctx_i.st;
    status = 1'b0;
    case (req_e'(item_i.req_type))
      REQ_TICK: begin
        ctx_o.idle = idle_new;
        case (ctx_i.st)
          ST_ACTIVE: begin
            go  = idle_cmp >= CMP_BITS'(cfg_i.dim_timeout);
            tgt = ST_DIM;
          end
          ST_DIM: begin
            go  = idle_cmp >= CMP_BITS'(cfg_i.light_timeout);
            tgt = ST_LIGHT;
          end
          ST_LIGHT: begin
            go  = idle_cmp >= CMP_BITS'(cfg_i.deep_timeout);
            tgt = ST_DEEP;
          end
          default: go = 1'b0;  // deep sleep only counts
        endcase
      end
      REQ_ACTIVITY: begin
        ctx_o.idle = '0;
        go  = (ctx_i.st == ST_DIM) || (ctx_i.st == ST_LIGHT);
        tgt = ST_ACTIVE;
      end
      REQ_CRITICAL: begin
        go  = 1'b1;
        tgt = ST_DEEP;
      end
      REQ_FORCE: begin
        if (item_i.target_state[2]) begin
          status = 1'b1;
        end else begin
          go  = 1'b1;
          tgt = code_state(item_i.target_state[1:0]);
        end
      end
      default: go = 1'b0;
    endcase

    move = go && (tgt != ctx_i.st);

    res_o                 = '0;
    res_o.status          = status;
    if (move) begin
      ctx_o.st            = tgt;
      res_o.state_changed = 1'b1;
      case (tgt)
        ST_ACTIVE: begin
          res_o.backlight_write = 1'b1;
          res_o.backlight_level = fit_level(cfg_i.active_level);
          ctx_o.radio_save      = 1'b0;
          ctx_o.service_on      = 1'b1;
          res_o.event_code      = EV_CHANGE;
        end
        ST_DIM: begin
          res_o.backlight_write = 1'b1;
          res_o.backlight_level = fit_level(cfg_i.dim_level);
          res_o.event_code      = EV_CHANGE;
        end
        ST_LIGHT: begin
          ctx_o.radio_save = 1'b1;
          ctx_o.service_on = 1'b0;
          res_o.event_code = EV_CHANGE;
        end
        default: begin
          res_o.event_code    = EV_DEEP;
          res_o.sleep_request = 1'b1;
        end
      endcase
    end

    res_o.power_state        = state_code(ctx_o.st);
    res_o.radio_power_save   = ctx_o.radio_save;
    res_o.network_service_on = ctx_o.service_on;
    res_o.idle_ms_out        = (CMP_BITS'(ctx_o.idle) > CMP_BITS'(32'hFFFF_FFFF))
                               ? 32'hFFFF_FFFF : 32'(ctx_o.idle);
  end

endmodule

// ----- src/idle_timeout_power_state_ladder_unit.sv -----
// Idle power ladder: active, dim, light sleep, deep sleep. One request per cycle
// while the result port takes results; an accepted input beat goes through the
// input register, then the single-pass state update into the result register.
// The rate is set by the state and idle-counter registers, which are updated in
// the same cycle as a request is evaluated, so back-to-back requests always see
// the previous one's effect. The user must write timeouts and backlight levels
// through the cfg port while no request is in flight; the block does not enforce it.
module idle_timeout_power_state_ladder_unit import ipsl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i,
  ipsl_in_if.sink                 in_i,
  ipsl_out_if.source              out_o
);

  cfg_t    cfg_q;
  ctx_t    ctx_q, ctx_d;
  item_t   item_q;
  logic    item_vld_q;
  result_t res_q, res_d;
  logic    res_vld_q;
  logic    adv;

  // result slot free, so the input stage can move on
  assign adv        = !res_vld_q || out_o.ready;
  assign in_i.ready = !item_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dim_timeout   <= RST_DIM_TIMEOUT;
      cfg_q.light_timeout <= RST_LIGHT_TIMEOUT;
      cfg_q.deep_timeout  <= RST_DEEP_TIMEOUT;
      cfg_q.dim_level     <= RST_DIM_LEVEL;
      cfg_q.active_level  <= RST_ACTIVE_LEVEL;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DIM_TIMEOUT:   cfg_q.dim_timeout   <= cfg_data_i;
        CFG_LIGHT_TIMEOUT: cfg_q.light_timeout <= cfg_data_i;
        CFG_DEEP_TIMEOUT:  cfg_q.deep_timeout  <= cfg_data_i;
        CFG_DIM_LEVEL:     cfg_q.dim_level     <= cfg_data_i[7:0];
        CFG_ACTIVE_LEVEL:  cfg_q.active_level  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.req_type     <= in_i.req_type;
      item_q.elapsed_ms   <= in_i.elapsed_ms;
      item_q.target_state <= in_i.target_state;
    end
    if (item_vld_q && adv) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q       <= 1'b0;
      res_vld_q        <= 1'b0;
      ctx_q.st         <= ST_ACTIVE;
      ctx_q.idle       <= '0;
      ctx_q.radio_save <= 1'b0;
      ctx_q.service_on <= 1'b1;
    end else begin
      if (in_i.ready) begin
        item_vld_q <= in_i.valid;
      end
      if (adv) begin
        res_vld_q <= item_vld_q;
      end
      if (item_vld_q && adv) begin
        ctx_q <= ctx_d;
      end
    end
  end

  ipsl_step u_step (
    .cfg_i  (cfg_q),
    .ctx_i  (ctx_q),
    .item_i (item_q),
    .ctx_o  (ctx_d),
    .res_o  (res_d)
  );

  assign out_o.valid              = res_vld_q;
  assign out_o.power_state        = res_q.power_state;
  assign out_o.state_changed      = res_q.state_changed;
  assign out_o.backlight_write    = res_q.backlight_write;
  assign out_o.backlight_level    = res_q.backlight_level;
  assign out_o.radio_power_save   = res_q.radio_power_save;
  assign out_o.network_service_on = res_q.network_service_on;
  assign out_o.event_code         = res_q.event_code;
  assign out_o.idle_ms_out        = res_q.idle_ms_out;
  assign out_o.status             = res_q.status;
  assign out_o.sleep_request      = res_q.sleep_request;

  // deep sleep entry beat carries the deep state and its event
  a_sleep_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.sleep_request |->
      out_o.power_state == CODE_DEEP && out_o.event_code == EV_DEEP
      && out_o.state_changed)
    else $error("sleep request without deep sleep entry");

  // a rejected force target never moves the state
  a_invalid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status |-> !out_o.state_changed && out_o.event_code == EV_NONE)
    else $error("invalid target changed state");

  // a result beat reflects the live state register while the input stage is empty
  a_state_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !item_vld_q |-> out_o.power_state == state_code(ctx_q.st))
    else $error("result state differs from state register");

  // a stalled result stage does not update the state
  a_ctx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(ctx_q))
    else $error("state moved while result stage stalled");

endmodule

// ----- tb/sv/tb_idle_timeout_power_state_ladder_unit.sv -----
`timescale 1ns / 100ps

module tb_idle_timeout_power_state_ladder_unit;
  import ipsl_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_TICKS  = 16;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [CFG_BITS-1:0]     cfg_data_i;

  ipsl_in_if  in_if ();
  ipsl_out_if out_if ();

  idle_timeout_power_state_ladder_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #10 clk_i = ~clk_i;

  // ladder predictor state and its copy of the registers
  logic [1:0]           lad_state      = CODE_ACTIVE;
  logic [IDLE_BITS-1:0] lad_idle       = '0;
  logic                 lad_radio_save = 1'b0;
  logic                 lad_service_on = 1'b1;
  logic [31:0]          cfg_dim_to, cfg_light_to, cfg_deep_to;
  logic [7:0]           cfg_dim_lvl, cfg_act_lvl;

  item_t   req_q[$];
  result_t ladder_expect_q[$];

  int   mismatches = 0;
  int   req_beats = 0;
  int   result_beats = 0;
  int   transitions = 0;
  int   bad_targets = 0;
  bit   saw_saturation = 1'b0;
  int   quiet_cycles = 0;

  // idling control
  bit   calm;
  bit   src_bursty, snk_bursty;
  int   mode_left = 0;
  int   src_gap, snk_gap;
  item_t drv_item;

  function automatic result_t ladder_step(input item_t it);
    result_t              r;
    logic [1:0]           nxt;
    logic                 move;
    logic [IDLE_BITS:0]   sum;
    logic [7:0]           lvl_mask;
    r        = '0;
    move     = 1'b0;
    nxt      = lad_state;
    lvl_mask = 8'((64'd1 << LEVEL_BITS) - 1);
    case (it.req_type)
      REQ_TICK: begin
        sum      = lad_idle + it.elapsed_ms;
        lad_idle = sum[IDLE_BITS] ? '1 : sum[IDLE_BITS-1:0];
        case (lad_state)
          CODE_ACTIVE: if (lad_idle >= cfg_dim_to) begin
            move = 1'b1;
            nxt  = CODE_DIM;
          end
          CODE_DIM: if (lad_idle >= cfg_light_to) begin
            move = 1'b1;
            nxt  = CODE_LIGHT;
          end
          CODE_LIGHT: if (lad_idle >= cfg_deep_to) begin
            move = 1'b1;
            nxt  = CODE_DEEP;
          end
          default: ;
        endcase
      end
      REQ_ACTIVITY: begin
        lad_idle = '0;
        if (lad_state == CODE_DIM || lad_state == CODE_LIGHT) begin
          move = 1'b1;
          nxt  = CODE_ACTIVE;
        end
      end
      REQ_CRITICAL: begin
        move = 1'b1;
        nxt  = CODE_DEEP;
      end
      default: begin
        if (it.target_state > {1'b0, CODE_DEEP}) begin
          r.status = 1'b1;
        end else begin
          move = 1'b1;
          nxt  = it.target_state[1:0];
        end
      end
    endcase
    // a move onto the current state is a no-op
    if (move && nxt != lad_state) begin
      lad_state       = nxt;
      r.state_changed = 1'b1;
      r.event_code    = EV_CHANGE;
      case (nxt)
        CODE_ACTIVE: begin
          r.backlight_write = 1'b1;
          r.backlight_level = cfg_act_lvl & lvl_mask;
          lad_radio_save    = 1'b0;
          lad_service_on    = 1'b1;
        end
        CODE_DIM: begin
          r.backlight_write = 1'b1;
          r.backlight_level = cfg_dim_lvl & lvl_mask;
        end
        CODE_LIGHT: begin
          lad_radio_save = 1'b1;
          lad_service_on = 1'b0;
        end
        default: begin
          r.event_code    = EV_DEEP;
          r.sleep_request = 1'b1;
        end
      endcase
    end
    r.power_state        = lad_state;
    r.radio_power_save   = lad_radio_save;
    r.network_service_on = lad_service_on;
    r.idle_ms_out        = (lad_idle > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(lad_idle);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < 40)
      $display("mismatch on %s: got 0x%0h, want 0x%0h (result beat %0d, t=%0t)",
               what, got, want, result_beats, $time);
    mismatches++;
  endtask

  // stimulus helpers
  task automatic push_req(input logic [1:0] req, input logic [15:0] ms, input logic [2:0] tgt);
    item_t it;
    it.req_type     = req;
    it.elapsed_ms   = ms;
    it.target_state = tgt;
    req_q.push_back(it);
  endtask

  task automatic queue_random(input int n);
    int          pick;
    logic [15:0] ms;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      ms   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                         : 16'($urandom_range(0, 4000));
      // ticks dominate so the ladder actually gets walked down
      if (pick < 55)      push_req(REQ_TICK, ms, 3'($urandom_range(0, 7)));
      else if (pick < 70) push_req(REQ_ACTIVITY, ms, 3'($urandom_range(0, 7)));
      else if (pick < 78) push_req(REQ_CRITICAL, ms, 3'($urandom_range(0, 7)));
      else                push_req(REQ_FORCE, ms, 3'($urandom_range(0, 7)));
    end
  endtask

  function automatic logic [31:0] rand_timeout();
    return $urandom_range(0, 1) ? 32'($urandom()) : 32'($urandom_range(1, 200000));
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (req_q.size() != 0 || in_if.valid || ladder_expect_q.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
  endtask

  // only called with nothing in flight
  task automatic set_config(input logic [31:0] dim_to, input logic [31:0] light_to,
                            input logic [31:0] deep_to, input logic [7:0] dim_lvl,
                            input logic [7:0] act_lvl);
    write_reg(CFG_DIM_TIMEOUT, dim_to);
    write_reg(CFG_LIGHT_TIMEOUT, light_to);
    write_reg(CFG_DEEP_TIMEOUT, deep_to);
    write_reg(CFG_DIM_LEVEL, {24'd0, dim_lvl});
    write_reg(CFG_ACTIVE_LEVEL, {24'd0, act_lvl});
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    cfg_dim_to   = dim_to;
    cfg_light_to = light_to;
    cfg_deep_to  = deep_to;
    cfg_dim_lvl  = dim_lvl;
    cfg_act_lvl  = act_lvl;
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid        <= 1'b0;
      in_if.req_type     <= REQ_TICK;
      in_if.elapsed_ms   <= '0;
      in_if.target_state <= '0;
      src_gap = 0;
    end else if (!(in_if.valid && !in_if.ready)) begin
      if (src_gap > 0) begin
        src_gap--;
        in_if.valid <= 1'b0;
      end else if (!calm && src_bursty && $urandom_range(0, 4) == 0) begin
        src_gap = $urandom_range(0, 10);
        in_if.valid <= 1'b0;
      end else if (req_q.size() != 0) begin
        drv_item = req_q.pop_front();
        in_if.valid        <= 1'b1;
        in_if.req_type     <= drv_item.req_type;
        in_if.elapsed_ms   <= drv_item.elapsed_ms;
        in_if.target_state <= drv_item.target_state;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result sink backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      snk_gap = 0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      out_if.ready <= 1'b0;
    end else if (!calm && snk_bursty && $urandom_range(0, 4) == 0) begin
      snk_gap = $urandom_range(0, 10);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // alternate stretches with and without idling
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      src_bursty <= ($urandom_range(0, 2) != 0);
      snk_bursty <= ($urandom_range(0, 2) != 0);
      mode_left  <= $urandom_range(20, 120);
    end else begin
      mode_left  <= mode_left - 1;
    end
  end

  // monitor: predict on request beats, then check result beats
  always @(posedge clk_i) begin
    result_t got, want;
    item_t   seen;
    if (rst_ni && in_if.valid && in_if.ready) begin
      seen.req_type     = in_if.req_type;
      seen.elapsed_ms   = in_if.elapsed_ms;
      seen.target_state = in_if.target_state;
      ladder_expect_q.push_back(ladder_step(seen));
      req_beats++;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.power_state        = out_if.power_state;
      got.state_changed      = out_if.state_changed;
      got.backlight_write    = out_if.backlight_write;
      got.backlight_level    = out_if.backlight_level;
      got.radio_power_save   = out_if.radio_power_save;
      got.network_service_on = out_if.network_service_on;
      got.event_code         = out_if.event_code;
      got.idle_ms_out        = out_if.idle_ms_out;
      got.status             = out_if.status;
      got.sleep_request      = out_if.sleep_request;
      if (ladder_expect_q.size() == 0) begin
        report_mismatch("result beat with nothing pending", got, 0);
      end else begin
        want = ladder_expect_q.pop_front();
        if (got.power_state !== want.power_state)
          report_mismatch("power_state", got.power_state, want.power_state);
        if (got.state_changed !== want.state_changed)
          report_mismatch("state_changed", got.state_changed, want.state_changed);
        if (got.backlight_write !== want.backlight_write)
          report_mismatch("backlight_write", got.backlight_write, want.backlight_write);
        if (got.backlight_level !== want.backlight_level)
          report_mismatch("backlight_level", got.backlight_level, want.backlight_level);
        if (got.radio_power_save !== want.radio_power_save)
          report_mismatch("radio_power_save", got.radio_power_save, want.radio_power_save);
        if (got.network_service_on !== want.network_service_on)
          report_mismatch("network_service_on", got.network_service_on,
                          want.network_service_on);
        if (got.event_code !== want.event_code)
          report_mismatch("event_code", got.event_code, want.event_code);
        if (got.idle_ms_out !== want.idle_ms_out)
          report_mismatch("idle_ms_out", got.idle_ms_out, want.idle_ms_out);
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
        if (got.sleep_request !== want.sleep_request)
          report_mismatch("sleep_request", got.sleep_request, want.sleep_request);
        if (want.state_changed) transitions++;
        if (want.status) bad_targets++;
        if (want.idle_ms_out == 32'hFFFF_FFFF) saw_saturation = 1'b1;
      end
      result_beats++;
    end
  end

  // watchdog on cycles without any beat or register write
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we_i)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no progress for %0d cycles, %0d results still pending",
                 QUIET_LIMIT, ladder_expect_q.size());
        $display("FAIL idle_timeout_power_state_ladder_unit");
        $finish;
      end
    end
  end

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_DIM_TIMEOUT;
    cfg_data_i          = '0;
    calm                = 1'b1;
    cfg_dim_to          = RST_DIM_TIMEOUT;
    cfg_light_to        = RST_LIGHT_TIMEOUT;
    cfg_deep_to         = RST_DEEP_TIMEOUT;
    cfg_dim_lvl         = RST_DIM_LEVEL;
    cfg_act_lvl         = RST_ACTIVE_LEVEL;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    calm = 1'b0;

    // walk the ladder with reset timeouts
    push_req(REQ_TICK, 16'h0000, 3'd0);
    push_req(REQ_TICK, 16'hFFFF, 3'd0);     // active -> dim
    push_req(REQ_TICK, 16'hFFFF, 3'd7);     // dim -> light
    push_req(REQ_ACTIVITY, 16'h0000, 3'd0); // wake
    push_req(REQ_TICK, 16'hFFFF, 3'd0);
    push_req(REQ_ACTIVITY, 16'hFFFF, 3'd7);
    push_req(REQ_CRITICAL, 16'h0000, 3'd0);
    push_req(REQ_CRITICAL, 16'h0000, 3'd0); // already deep
    push_req(REQ_TICK, 16'hFFFF, 3'd0);     // deep only counts
    push_req(REQ_ACTIVITY, 16'h0000, 3'd0); // deep stays, counter clears
    push_req(REQ_FORCE, 16'h0000, 3'd7);
    push_req(REQ_FORCE, 16'h5555, 3'd4);
    push_req(REQ_FORCE, 16'h0000, 3'd0);    // force out of deep
    push_req(REQ_FORCE, 16'h0000, 3'd0);
    push_req(REQ_FORCE, 16'h0000, 3'd1);
    push_req(REQ_FORCE, 16'h0000, 3'd2);
    push_req(REQ_FORCE, 16'h0000, 3'd3);
    push_req(REQ_FORCE, 16'h0000, 3'd1);
    push_req(REQ_TICK, 16'hFFFF, 3'd0);
    push_req(REQ_TICK, 16'hFFFF, 3'd0);
    push_req(REQ_FORCE, 16'h0000, 3'd0);    // forced move keeps the counter
    push_req(REQ_TICK, 16'h0000, 3'd0);     // so this dims right away
    push_req(REQ_FORCE, 16'hAAAA, 3'd5);
    push_req(REQ_ACTIVITY, 16'h0000, 3'd0);
    wait_drained();

    // zero timeouts: every tick above deep sleep steps down
    set_config(32'd0, 32'd0, 32'd0, 8'd1, 8'd255);
    push_req(REQ_FORCE, 16'h0000, 3'd0);
    push_req(REQ_TICK, 16'h0000, 3'd0);
    push_req(REQ_TICK, 16'h0000, 3'd0);
    push_req(REQ_TICK, 16'h0000, 3'd0);
    push_req(REQ_ACTIVITY, 16'h0000, 3'd0);
    push_req(REQ_FORCE, 16'h0000, 3'd2);
    push_req(REQ_ACTIVITY, 16'h0000, 3'd0);
    push_req(REQ_TICK, 16'h0000, 3'd0);
    queue_random(20);
    wait_drained();

    // all-ones timeouts, then a run of long ticks that never leaves active
    set_config('1, '1, '1, 8'd255, 8'd1);
    calm = 1'b1;
    push_req(REQ_FORCE, 16'h0000, 3'd0);
    push_req(REQ_ACTIVITY, 16'h0000, 3'd0);
    for (int k = 0; k < LONG_TICKS; k++)
      push_req(REQ_TICK, 16'hFFFF, 3'($urandom_range(0, 7)));
    push_req(REQ_ACTIVITY, 16'h0000, 3'd0);
    wait_drained();
    calm = 1'b0;

    // short random timeouts so the ladder moves often
    set_config($urandom_range(1, 3000), $urandom_range(1, 8000), $urandom_range(1, 20000),
               8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
    queue_random(130);
    wait_drained();

    set_config(rand_timeout(), rand_timeout(), rand_timeout(),
               8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
    queue_random(110);
    wait_drained();

    // back to the reset values; the tail runs with no idling at all
    set_config(RST_DIM_TIMEOUT, RST_LIGHT_TIMEOUT, RST_DEEP_TIMEOUT,
               RST_DIM_LEVEL, RST_ACTIVE_LEVEL);
    queue_random(80);
    wait_drained();
    calm = 1'b1;
    queue_random(40);
    wait_drained();
    repeat (8) @(negedge clk_i);

    $display("covered %0d request beats (%0d long ticks under all-ones timeouts), %0d results",
             req_beats, LONG_TICKS, result_beats);
    $display("%0d state transitions, %0d invalid force targets, idle counter saturated: %0s",
             transitions, bad_targets, saw_saturation ? "yes" : "no");
    if (mismatches == 0 && ladder_expect_q.size() == 0) begin
      $display("PASS idle_timeout_power_state_ladder_unit");
    end else begin
      $display("FAIL idle_timeout_power_state_ladder_unit");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/ipsl_pkg.sv
src/ipsl_if.sv
src/ipsl_step.sv
src/idle_timeout_power_state_ladder_unit.sv
tb/sv/tb_idle_timeout_power_state_ladder_unit.sv
